// ===== rtl/grhc_pkg.sv =====
// Shared types, register codes and constants of the golden-ratio hue color generator.
package grhc_pkg;

    localparam int GRHC_PHASE_BITS = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int HUE_W     = 16;
    localparam int BYTE_W    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_STEP   = 2'd2;

    localparam logic [CFG_W-1:0] SATURATION_RST = 16'd62259;
    localparam logic [CFG_W-1:0] BRIGHTNESS_RST = 16'd62259;
    localparam logic [CFG_W-1:0] HUE_STEP_RST   = 16'd40503;

    localparam logic [0:0] REQ_NEXT = 1'b0;
    localparam logic [0:0] REQ_SEED = 1'b1;

    // Shared multiplier operand widths: a factor of up to 32 bits times v*255.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // One-cycle commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // transaction accepted: update the hue phase
        logic prep;     // sector, fraction and v*255
        logic mul_sf;   // s * f
        logic mul_p;    // v*255 * (1 - s)
        logic mul_q;    // v*255 * s*f
        logic mul_t;    // v*255 * s*(1 - f)
        logic fin;      // select components into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/grhc_ctrl.sv =====
// Sequencer of the golden-ratio hue color generator.
module grhc_ctrl
    import grhc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_SF   = 3'd2;
    localparam logic [2:0] S_MP   = 3'd3;
    localparam logic [2:0] S_MQ   = 3'd4;
    localparam logic [2:0] S_MT   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
                if (accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_SF;
            end
            S_SF: begin
                o_cmd.mul_sf = 1'b1;
                n_state      = S_MP;
            end
            S_MP: begin
                o_cmd.mul_p = 1'b1;
                n_state     = S_MQ;
            end
            S_MQ: begin
                o_cmd.mul_q = 1'b1;
                n_state     = S_MT;
            end
            S_MT: begin
                o_cmd.mul_t = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                // Wait here while the previous color is still held downstream.
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/grhc_dp.sv =====
// Datapath: hue phase, configuration registers, shared multiplier and output register.
module grhc_dp
    import grhc_pkg::*;
#(
    parameter int PHASE_BITS = GRHC_PHASE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_req_type,
    input  logic [HUE_W-1:0]     i_seed_hue,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [BYTE_W-1:0]    o_red,
    output logic [BYTE_W-1:0]    o_green,
    output logic [BYTE_W-1:0]    o_blue,
    output logic [HUE_W-1:0]     o_hue_now
);

    localparam int EXT_W = (PHASE_BITS > HUE_W) ? PHASE_BITS : HUE_W;
    localparam int SCL_W = PHASE_BITS + 3;

    logic [CFG_W-1:0]      r_sat;
    logic [CFG_W-1:0]      r_bri;
    logic [CFG_W-1:0]      r_step;
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;

    logic [2:0]            r_sector;
    logic [HUE_W-1:0]      r_f16;
    logic [MUL_B_W-1:0]    r_w;
    logic [31:0]           r_m1;
    logic [31:0]           r_m2;
    logic [PROD_W-1:0]     r_prod;
    logic [BYTE_W-1:0]     r_pb;
    logic [BYTE_W-1:0]     r_qb;

    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_red;
    logic [BYTE_W-1:0]     r_green;
    logic [BYTE_W-1:0]     r_blue;
    logic [HUE_W-1:0]      r_hue_now;

    logic [EXT_W-1:0]      seed_ext;
    logic [EXT_W-1:0]      step_ext;
    logic [EXT_W-1:0]      phase_ext;
    logic [EXT_W-1:0]      frac_ext;
    logic [SCL_W-1:0]      scaled;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [PROD_W-1:0]     mul_prod;
    logic [PROD_W-1:0]     diff;
    logic [BYTE_W-1:0]     vb;
    logic [BYTE_W-1:0]     tb;
    logic [BYTE_W-1:0]     n_red;
    logic [BYTE_W-1:0]     n_green;
    logic [BYTE_W-1:0]     n_blue;

    assign seed_ext  = EXT_W'(i_seed_hue);
    assign step_ext  = EXT_W'(r_step);
    assign phase_ext = EXT_W'(r_phase);
    assign n_phase   = (i_req_type == REQ_SEED) ? seed_ext[PHASE_BITS-1:0]
                                                : r_phase + step_ext[PHASE_BITS-1:0];

    // Six times the hue: the top three bits are the sector, the rest the fraction.
    assign scaled   = (SCL_W'(r_phase) << 2) + (SCL_W'(r_phase) << 1);
    assign frac_ext = EXT_W'(scaled[PHASE_BITS-1:0]) << (EXT_W - PHASE_BITS);

    always_comb begin
        mul_b = r_w;
        mul_a = r_m1;
        priority if (i_cmd.mul_sf) begin
            mul_a = MUL_A_W'(r_sat);
            mul_b = MUL_B_W'(r_f16);
        end else if (i_cmd.mul_p) begin
            mul_a = MUL_A_W'(17'h10000 - 17'(r_sat));
        end else if (i_cmd.mul_q) begin
            mul_a = r_m1;
        end else begin
            mul_a = r_m2;
        end
    end

    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // v*255*(1 - x) with x in Q0.32 is (v*255 << 32) - v*255*x.
    assign diff = {r_w, 32'd0} - r_prod;
    assign vb   = r_w[23:16];
    assign tb   = diff[PROD_W-1 -: BYTE_W];

    always_comb begin
        n_red   = vb;
        n_green = vb;
        n_blue  = vb;
        if (r_sat != '0) begin
            unique case (r_sector)
                3'd0: begin n_red = vb;   n_green = tb;   n_blue = r_pb; end
                3'd1: begin n_red = r_qb; n_green = vb;   n_blue = r_pb; end
                3'd2: begin n_red = r_pb; n_green = vb;   n_blue = tb;   end
                3'd3: begin n_red = r_pb; n_green = r_qb; n_blue = vb;   end
                3'd4: begin n_red = tb;   n_green = r_pb; n_blue = vb;   end
                default: begin n_red = vb; n_green = r_pb; n_blue = r_qb; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat       <= SATURATION_RST;
            r_bri       <= BRIGHTNESS_RST;
            r_step      <= HUE_STEP_RST;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SATURATION: r_sat  <= i_cfg_data;
                    REG_BRIGHTNESS: r_bri  <= i_cfg_data;
                    REG_HUE_STEP:   r_step <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_phase <= n_phase;
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_sector <= scaled[SCL_W-1 -: 3];
            r_f16    <= frac_ext[EXT_W-1 -: HUE_W];
            r_w      <= ({8'd0, r_bri} << 8) - MUL_B_W'(r_bri);
        end
        if (i_cmd.mul_sf || i_cmd.mul_p || i_cmd.mul_q || i_cmd.mul_t) begin
            r_prod <= mul_prod;
        end
        if (i_cmd.mul_p) begin
            r_m1 <= r_prod[31:0];
        end
        if (i_cmd.mul_q) begin
            r_pb <= r_prod[39:32];
            r_m2 <= {r_sat, 16'd0} - r_m1;
        end
        if (i_cmd.mul_t) begin
            r_qb <= diff[PROD_W-1 -: BYTE_W];
        end
        if (i_cmd.fin) begin
            r_red     <= n_red;
            r_green   <= n_green;
            r_blue    <= n_blue;
            r_hue_now <= phase_ext[HUE_W-1:0];
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_red           = r_red;
    assign o_green         = r_green;
    assign o_blue          = r_blue;
    assign o_hue_now       = r_hue_now;

endmodule

// ===== rtl/golden_ratio_hue_color_generator_core.sv =====
// Top level of the golden-ratio hue color generator.
//
//  channel   direction  payload                                   transaction
//  s_axis    in         tdata: seed_hue; tuser: req_type          tvalid & tready
//  m_axis    out        tdata: red, green, blue, hue_now          tvalid & tready
//  i_cfg     in         i_cfg_idx, i_cfg_data                     i_cfg_we
//
// From acceptance until its color is registered, an item passes through
// one phase update, then six steps of the sequencer, four of which
// go through the single shared 32x24 multiplier (s*f, then p, q and t).
// The next item is accepted as soon as the sequencer is back in idle, while a
// finished color may still wait in the output register. A stalled output
// holds the sequencer in its final step. Reset clears the phase and loads the
// default saturation, brightness and hue step.
module golden_ratio_hue_color_generator_core
    import grhc_pkg::*;
#(
    parameter int PHASE_BITS = GRHC_PHASE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] seed_hue
    input  logic [0:0]           s_axis_tuser,   // [0] req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,   // [7:0] red, [15:8] green,
                                                 // [23:16] blue, [39:24] hue_now
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [HUE_W-1:0]  hue_now;

    grhc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    grhc_dp #(
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (s_axis_tuser[0]),
        .i_seed_hue  (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_red       (red),
        .o_green     (green),
        .o_blue      (blue),
        .o_hue_now   (hue_now)
    );

    assign m_axis_tdata = {hue_now, blue, green, red};

    // An accepted transaction keeps the input closed while the color is worked out.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted transaction");

    // A new color never overwrites one that is still held downstream.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten while stalled");

    // Finishing a color always presents it on the next cycle.
    a_fin_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |=> m_axis_tvalid)
        else $error("finished color not presented");

    // Only one datapath step is commanded at a time.
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("several datapath steps commanded at once");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the golden-ratio hue color generator core.
`timescale 1ns / 1ps

module tb_top;
    import grhc_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 12;
    localparam int N_PHASES      = 12;
    localparam int PHASE_ITEMS   = 150;
    localparam int N_DIR         = 36;
    localparam int MAX_REPORTS   = 10;

    // Index outside the register map; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Same bit order as m_axis_tdata: red in the lowest byte.
    typedef struct packed {
        logic [HUE_W-1:0]  hue_now;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
    } t_color;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic                  req;
        logic [15:0]           val;     // seed hue or register data
        logic [CFG_IDX_W-1:0]  idx;
        logic                  typed;   // expected color given in the row
        logic [7:0]            r;
        logic [7:0]            g;
        logic [7:0]            b;
        logic [15:0]           hue;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [39:0]          m_axis_tdata;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    golden_ratio_hue_color_generator_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow copy of the block's registers and hue phase.
    logic [15:0] cur_sat;
    logic [15:0] cur_bright;
    logic [15:0] cur_step;
    logic [15:0] hue_acc;

    t_color exp_colors[$];
    int     color_errs;
    int     cycles;
    int     burst_left;
    int     gap_max;

    t_row dir_rows [0:N_DIR-1] = '{
        '{ROW_ITEM, REQ_SEED, 16'h0000, REG_SATURATION, 1'b1, 8'd242, 8'd12, 8'd12, 16'h0000},
        '{ROW_ITEM, REQ_NEXT, 16'hFFFF, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_NEXT, 16'h0000, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'hFFFF, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_NEXT, 16'h0000, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'd10922, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'd10923, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'd21845, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'd21846, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'd32768, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'd43691, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'd54613, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'd54614, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_CFG,  REQ_NEXT, 16'h0000, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'h1234, REG_SATURATION, 1'b1, 8'd242, 8'd242, 8'd242, 16'h1234},
        '{ROW_CFG,  REQ_NEXT, 16'hFFFF, REG_BRIGHTNESS, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'hABCD, REG_SATURATION, 1'b1, 8'd254, 8'd254, 8'd254, 16'hABCD},
        '{ROW_CFG,  REQ_NEXT, 16'hFFFF, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'h0000, REG_SATURATION, 1'b1, 8'd254, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'h8000, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_CFG,  REQ_NEXT, 16'h0000, REG_BRIGHTNESS, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'h5555, REG_SATURATION, 1'b1, 8'd0, 8'd0, 8'd0, 16'h5555},
        '{ROW_CFG,  REQ_NEXT, 16'hFFFF, REG_BRIGHTNESS, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_CFG,  REQ_NEXT, 16'h0000, REG_HUE_STEP,   1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_NEXT, 16'h0000, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_NEXT, 16'hFFFF, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_CFG,  REQ_NEXT, 16'hFFFF, REG_HUE_STEP,   1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_NEXT, 16'h0000, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_NEXT, 16'h0000, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_CFG,  REQ_NEXT, 16'h0000, REG_UNUSED,     1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_NEXT, 16'h0000, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_CFG,  REQ_NEXT, 16'h0001, REG_HUE_STEP,   1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_NEXT, 16'h0000, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_CFG,  REQ_NEXT, 16'h0001, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_SEED, 16'h0001, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000},
        '{ROW_ITEM, REQ_NEXT, 16'h0000, REG_SATURATION, 1'b0, 8'd0, 8'd0, 8'd0, 16'h0000}
    };

    // floor(v * x * 255 / 2^(16 + sh)) for a Q0.sh factor x.
    function automatic logic [7:0] comp_byte(input logic [63:0] v, input logic [63:0] x,
                                             input int sh);
        logic [63:0] prod;
        prod = (v * x * 64'd255) >> (16 + sh);
        return prod[7:0];
    endfunction

    function automatic t_color hsv_to_color(input logic [15:0] h, input logic [15:0] s,
                                            input logic [15:0] v);
        t_color      c;
        logic [63:0] h64, s64, v64, scaled, f16;
        logic [7:0]  vb, pb, qb, tb;
        logic [2:0]  sector;
        h64 = {48'd0, h};
        s64 = {48'd0, s};
        v64 = {48'd0, v};
        c.hue_now = h;
        vb = comp_byte(v64, 64'd65536, 16);
        if (s == 16'd0) begin
            c.red   = vb;
            c.green = vb;
            c.blue  = vb;
            return c;
        end
        scaled = h64 * 64'd6;
        sector = scaled[18:16];
        f16    = scaled & 64'hFFFF;
        pb = comp_byte(v64, 64'd65536 - s64, 16);
        qb = comp_byte(v64, (64'd65536 << 16) - s64 * f16, 32);
        tb = comp_byte(v64, (64'd65536 << 16) - s64 * (64'd65536 - f16), 32);
        case (sector)
            3'd0: begin c.red = vb; c.green = tb; c.blue = pb; end
            3'd1: begin c.red = qb; c.green = vb; c.blue = pb; end
            3'd2: begin c.red = pb; c.green = vb; c.blue = tb; end
            3'd3: begin c.red = pb; c.green = qb; c.blue = vb; end
            3'd4: begin c.red = tb; c.green = pb; c.blue = vb; end
            default: begin c.red = vb; c.green = pb; c.blue = qb; end
        endcase
        return c;
    endfunction

    function automatic logic [15:0] pick_cfg();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001;
            3: return 16'hFFFE;
            default: return 16'($urandom);
        endcase
    endfunction

    // First hue of each sector above zero.
    function automatic int sector_start(input int k);
        case (k)
            1: return 10923;
            2: return 21846;
            3: return 32768;
            4: return 43691;
            default: return 54614;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Called at a falling edge while the block is idle.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_SATURATION: cur_sat    = data;
            REG_BRIGHTNESS: cur_bright = data;
            REG_HUE_STEP:   cur_step   = data;
            default: ;
        endcase
    endtask

    task automatic send_item(input logic req, input logic [15:0] seed, input logic typed,
                             input t_color typed_color);
        t_color want;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = seed;
        s_axis_tuser  = req;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        if (req == REQ_SEED)
            hue_acc = seed;
        else
            hue_acc = hue_acc + cur_step;
        want = typed ? typed_color : hsv_to_color(hue_acc, cur_sat, cur_bright);
        exp_colors.push_back(want);
        @(negedge i_clk);
    endtask

    // Ends a burst now and then with a gap of random length.
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) begin
                    @(negedge i_clk);
                    s_axis_tdata = 16'($urandom);
                    s_axis_tuser = 1'($urandom);
                end
            end
        end
    endtask

    task automatic wait_empty();
        s_axis_tvalid = 1'b0;
        do @(negedge i_clk); while (exp_colors.size() != 0);
    endtask

    // Stop sending, collect every color, then give the sequencer time to return to idle.
    task automatic drain();
        wait_empty();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Receiver: the stall pattern changes after each run of random length.
    initial begin
        int rx_mode, rx_len, rx_tick;
        m_axis_tready = 1'b0;
        rx_tick = 0;
        @(posedge i_rst_n);
        forever begin
            rx_mode = $urandom_range(0, 3);
            rx_len  = $urandom_range(30, 300);
            repeat (rx_len) begin
                @(negedge i_clk);
                rx_tick++;
                case (rx_mode)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = 1'($urandom);
                    2: m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = ((rx_tick % 7) >= 3);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_color got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (exp_colors.size() == 0) begin
                color_errs++;
                if (color_errs <= MAX_REPORTS)
                    $display("unexpected color r=%0d g=%0d b=%0d hue=%h",
                             got.red, got.green, got.blue, got.hue_now);
            end else begin
                want = exp_colors.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.hue_now !== want.hue_now) begin
                    color_errs++;
                    if (color_errs <= MAX_REPORTS)
                        $display("color mismatch: exp r=%0d g=%0d b=%0d hue=%h, got r=%0d g=%0d b=%0d hue=%h",
                                 want.red, want.green, want.blue, want.hue_now,
                                 got.red, got.green, got.blue, got.hue_now);
                end
            end
        end
    end

    initial begin
        int          ph, k, hold_at, pick;
        logic        req;
        logic [15:0] seed;
        t_color      typed_color;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'd0;
        s_axis_tuser  = REQ_NEXT;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_SATURATION;
        i_cfg_data    = 16'd0;
        color_errs    = 0;
        cycles        = 0;
        burst_left    = 0;
        gap_max       = 3;
        cur_sat       = SATURATION_RST;
        cur_bright    = BRIGHTNESS_RST;
        cur_step      = HUE_STEP_RST;
        hue_acc       = 16'd0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        for (k = 0; k < N_DIR; k++) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                drain();
                cfg_write(dir_rows[k].idx, dir_rows[k].val);
            end else begin
                typed_color.red     = dir_rows[k].r;
                typed_color.green   = dir_rows[k].g;
                typed_color.blue    = dir_rows[k].b;
                typed_color.hue_now = dir_rows[k].hue;
                send_item(dir_rows[k].req, dir_rows[k].val, dir_rows[k].typed, typed_color);
                pace();
            end
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            drain();
            if (ph == 0) begin
                cfg_write(REG_SATURATION, 16'hFFFF);
                cfg_write(REG_BRIGHTNESS, 16'hFFFF);
                cfg_write(REG_HUE_STEP, 16'hFFFF);
            end else if (ph == 1) begin
                cfg_write(REG_SATURATION, 16'h0001);
                cfg_write(REG_BRIGHTNESS, 16'h0001);
                cfg_write(REG_HUE_STEP, 16'h0001);
            end else if (ph == N_PHASES - 1) begin
                cfg_write(REG_SATURATION, SATURATION_RST);
                cfg_write(REG_BRIGHTNESS, BRIGHTNESS_RST);
                cfg_write(REG_HUE_STEP, HUE_STEP_RST);
            end else begin
                cfg_write(REG_SATURATION, pick_cfg());
                cfg_write(REG_BRIGHTNESS, ($urandom_range(0, 2) == 0) ? pick_cfg()
                                                                       : 16'($urandom));
                cfg_write(REG_HUE_STEP, pick_cfg());
            end
            if ($urandom_range(0, 1) == 1)
                cfg_write(REG_UNUSED, 16'($urandom));

            gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 10);
            hold_at = $urandom_range(10, PHASE_ITEMS - 10);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // Hold the sender back until the output side has caught up.
                if (k == hold_at)
                    wait_empty();
                req = ($urandom_range(0, 9) < 7) ? REQ_NEXT : REQ_SEED;
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    seed = 16'(sector_start($urandom_range(1, 5)) + $urandom_range(0, 3) - 2);
                else if (pick == 2)
                    seed = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
                else
                    seed = 16'($urandom);
                send_item(req, seed, 1'b0, '0);
                pace();
            end
        end

        wait_empty();
        repeat (2 * SETTLE_CYCLES) @(negedge i_clk);
        if (color_errs == 0 && exp_colors.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/grhc_pkg.sv
rtl/grhc_ctrl.sv
rtl/grhc_dp.sv
rtl/golden_ratio_hue_color_generator_core.sv
test/tb_top.sv
